// ===== src/bccb_pkg.sv =====
// ----------------------------------------------------------------------------
// bccb_pkg
// shared types, widths and codes of the byte column compare bitmap block
// ----------------------------------------------------------------------------
package bccb_pkg;

  localparam int DATA_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int LANES_MAX = 8;
  localparam int SLOTS     = 8;
  localparam int SLOT_W    = 3;
  localparam int VALID_W   = 4;
  localparam int IDX_W     = 16;
  localparam int MAXW_W    = 26;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int MAX_WORDS_DEF      = 65536;
  localparam int BYTES_PER_ITEM_DEF = 8;

  localparam logic [2:0] CMP_GT = 3'd0;
  localparam logic [2:0] CMP_GE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  localparam logic [1:0] CMB_AND  = 2'd0;
  localparam logic [1:0] CMB_OR   = 2'd1;
  localparam logic [1:0] CMB_ANDN = 2'd2;

  localparam logic [1:0] REG_COMPARE_OP    = 2'd0;
  localparam logic [1:0] REG_COMBINE_OP    = 2'd1;
  localparam logic [1:0] REG_SIGNED_MODE   = 2'd2;
  localparam logic [1:0] REG_COMPARE_VALUE = 2'd3;

  typedef struct packed {
    logic [2:0]        compare_op;
    logic [1:0]        combine_op;
    logic              signed_mode;
    logic [BYTE_W-1:0] compare_value;
  } cfg_t;

endpackage

// ===== src/bccb_if.sv =====
// ----------------------------------------------------------------------------
// bccb channel interfaces
// valid/ready channels for column words and emitted match words
// ----------------------------------------------------------------------------
interface bccb_in_if;
  import bccb_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_bytes;
  logic [VALID_W-1:0] valid_bytes;
  logic               last_in_set;
  logic [DATA_W-1:0]  prior_match;

  modport source (output valid, data_bytes, valid_bytes, last_in_set, prior_match,
                  input ready);
  modport sink (input valid, data_bytes, valid_bytes, last_in_set, prior_match,
                output ready);
endinterface

interface bccb_out_if;
  import bccb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] match_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, match_word, word_index, last_word, input ready);
  modport sink (input valid, match_word, word_index, last_word, output ready);
endinterface

// ===== src/bccb_cfg.sv =====
// ----------------------------------------------------------------------------
// bccb_cfg
// apb register file holding compare and combine settings
// ----------------------------------------------------------------------------
module bccb_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bccb_pkg::PADDR_W-1:0] paddr,
  input  logic [bccb_pkg::PDATA_W-1:0] pwdata,
  output logic [bccb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output bccb_pkg::cfg_t               cfg
);
  import bccb_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_COMPARE_OP:    cfg.compare_op    <= pwdata[2:0];
        REG_COMBINE_OP:    cfg.combine_op    <= pwdata[1:0];
        REG_SIGNED_MODE:   cfg.signed_mode   <= pwdata[0];
        REG_COMPARE_VALUE: cfg.compare_value <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COMPARE_OP:    prdata = PDATA_W'(cfg.compare_op);
      REG_COMBINE_OP:    prdata = PDATA_W'(cfg.combine_op);
      REG_SIGNED_MODE:   prdata = PDATA_W'(cfg.signed_mode);
      REG_COMPARE_VALUE: prdata = PDATA_W'(cfg.compare_value);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/bccb_lane.sv =====
// ----------------------------------------------------------------------------
// bccb_lane
// one byte comparator, signed or unsigned, six relations
// ----------------------------------------------------------------------------
module bccb_lane (
  input  bccb_pkg::cfg_t                cfg,
  input  logic [bccb_pkg::BYTE_W-1:0]   col_byte,
  input  logic                          en,
  output logic                          match
);
  import bccb_pkg::*;

  logic [BYTE_W-1:0] key_a;
  logic [BYTE_W-1:0] key_v;
  logic              hit;

  // flip the sign bit so an unsigned compare orders two's complement values
  assign key_a = col_byte ^ {cfg.signed_mode, {(BYTE_W-1){1'b0}}};
  assign key_v = cfg.compare_value ^ {cfg.signed_mode, {(BYTE_W-1){1'b0}}};

  always_comb begin
    case (cfg.compare_op)
      CMP_GT:  hit = key_a > key_v;
      CMP_GE:  hit = key_a >= key_v;
      CMP_LT:  hit = key_a < key_v;
      CMP_LE:  hit = key_a <= key_v;
      CMP_EQ:  hit = key_a == key_v;
      CMP_NE:  hit = key_a != key_v;
      default: hit = 1'b0;
    endcase
  end

  assign match = en && hit;

endmodule

// ===== src/bccb_merge.sv =====
// ----------------------------------------------------------------------------
// bccb_merge
// gathers lane bits into the group word, combines with prior and emits
// ----------------------------------------------------------------------------
module bccb_merge #(
  parameter int MAX_WORDS = bccb_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bccb_pkg::cfg_t                 cfg,
  input  logic [bccb_pkg::LANES_MAX-1:0] lane_bits,
  bccb_in_if.sink                        col_in,
  bccb_out_if.source                     bitmap_out
);
  import bccb_pkg::*;

  localparam logic [MAXW_W-1:0] MAX_LIM = MAXW_W'(MAX_WORDS);

  logic [DATA_W-1:0] partial_bits;
  logic [SLOT_W-1:0] group_slot;
  logic [IDX_W-1:0]  group_count;
  logic [DATA_W-1:0] bits_next;
  logic [DATA_W-1:0] merged;
  logic [IDX_W:0]    count_inc;
  logic [IDX_W-1:0]  group_count_next;
  logic              fire;
  logic              emit;

  assign col_in.ready = !bitmap_out.valid || bitmap_out.ready;
  assign fire         = col_in.valid && col_in.ready;
  assign emit         = (group_slot == SLOT_W'(SLOTS-1)) || col_in.last_in_set;

  always_comb begin
    bits_next = partial_bits;
    for (int s = 0; s < SLOTS; s++) begin
      if (group_slot == SLOT_W'(s)) begin
        bits_next[s*LANES_MAX +: LANES_MAX] = partial_bits[s*LANES_MAX +: LANES_MAX] | lane_bits;
      end
    end
  end

  always_comb begin
    case (cfg.combine_op)
      CMB_AND:  merged = col_in.prior_match & bits_next;
      CMB_OR:   merged = col_in.prior_match | bits_next;
      CMB_ANDN: merged = col_in.prior_match & ~bits_next;
      default:  merged = col_in.prior_match;
    endcase
  end

  assign count_inc        = {1'b0, group_count} + (IDX_W+1)'(1);
  assign group_count_next = (MAXW_W'(count_inc) >= MAX_LIM) ? '0 : count_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits     <= '0;
      group_slot       <= '0;
      group_count      <= '0;
      bitmap_out.valid <= 1'b0;
    end else begin
      if (fire) begin
        if (emit) begin
          partial_bits <= '0;
          group_slot   <= '0;
          group_count  <= col_in.last_in_set ? '0 : group_count_next;
        end else begin
          partial_bits <= bits_next;
          group_slot   <= group_slot + SLOT_W'(1);
        end
      end
      if (fire && emit) begin
        bitmap_out.valid <= 1'b1;
      end else if (bitmap_out.ready) begin
        bitmap_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      bitmap_out.match_word <= merged;
      bitmap_out.word_index <= group_count;
      bitmap_out.last_word  <= col_in.last_in_set;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    bitmap_out.valid && !bitmap_out.ready |-> !col_in.ready)
    else $error("input taken while result stalled");

  a_emit_clears_group: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> group_slot == '0 && partial_bits == '0 && bitmap_out.valid)
    else $error("group state not cleared after emit");

  a_slot_advances: assert property (@(posedge clk) disable iff (rst)
    fire && !emit |=> group_slot == $past(group_slot) + SLOT_W'(1) && !$past(bitmap_out.valid
      && !bitmap_out.ready))
    else $error("slot did not advance");

  a_last_resets_count: assert property (@(posedge clk) disable iff (rst)
    fire && col_in.last_in_set |=> group_count == '0 && bitmap_out.last_word)
    else $error("set end did not restart group count");

endmodule

// ===== src/byte_column_compare_bitmap.sv =====
// ----------------------------------------------------------------------------
// byte_column_compare_bitmap
// column scan predicate on bytes producing a 64-row match bitmap
// ----------------------------------------------------------------------------
// col_in takes one word of eight column bytes per transaction together with
// the valid byte count, the set end flag and the prior match word of the
// current 64-row group. bitmap_out gives one transaction per group: after
// eight words, or at a word flagged last_in_set, the gathered 64 match bits
// are combined with prior_match and emitted with the group index.
// Eight comparator lanes test all bytes of a word in the cycle it is taken;
// the result is in the output register in the cycle after the closing word.
// Throughput is one word per cycle; col_in.ready drops only while a result
// sits in the output register and bitmap_out.ready is low.
// Settings: compare relation, combine operation, signed mode, compare value.
// Users write them over the apb port while the block is idle (not enforced).
// Reset clears the settings, the partial group, the group index and the
// output valid flag.
// ----------------------------------------------------------------------------
module byte_column_compare_bitmap #(
  parameter int MAX_WORDS      = bccb_pkg::MAX_WORDS_DEF,
  parameter int BYTES_PER_ITEM = bccb_pkg::BYTES_PER_ITEM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  bccb_in_if.sink                      col_in,
  bccb_out_if.source                   bitmap_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bccb_pkg::PADDR_W-1:0] paddr,
  input  logic [bccb_pkg::PDATA_W-1:0] pwdata,
  output logic [bccb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bccb_pkg::*;

  cfg_t                 cfg;
  logic [LANES_MAX-1:0] lane_bits;

  bccb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar k = 0; k < LANES_MAX; k++) begin : g_lane
    if (k < BYTES_PER_ITEM) begin : g_on
      bccb_lane u_lane (
        .cfg      (cfg),
        .col_byte (col_in.data_bytes[k*BYTE_W +: BYTE_W]),
        .en       (VALID_W'(k) < col_in.valid_bytes),
        .match    (lane_bits[k])
      );
    end else begin : g_off
      assign lane_bits[k] = 1'b0;
    end
  end

  bccb_merge #(
    .MAX_WORDS (MAX_WORDS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .lane_bits  (lane_bits),
    .col_in     (col_in),
    .bitmap_out (bitmap_out)
  );

endmodule
